[design/locd_pkg.sv]
// ----------------------------------------------------------------------------
// locd_pkg
// Shared types and constants of the lock order cycle detector.
// ----------------------------------------------------------------------------
package locd_pkg;

  localparam int LOCK_ID_BITS      = 6;
  localparam int NODE_COUNT        = 1 << LOCK_ID_BITS;
  localparam int EDGE_DEPTH_DEF    = 64;
  localparam int FINDING_DEPTH_DEF = 32;
  localparam int SEQ_BITS          = 32;

  localparam logic [1:0] STATUS_DUPLICATE = 2'd0;
  localparam logic [1:0] STATUS_STORED    = 2'd1;
  localparam logic [1:0] STATUS_DROPPED   = 2'd2;

  localparam logic KIND_CYCLE    = 1'b0;
  localparam logic KIND_CAPACITY = 1'b1;

  typedef struct packed {
    logic [LOCK_ID_BITS-1:0] from_lock;
    logic [LOCK_ID_BITS-1:0] to_lock;
    logic [SEQ_BITS-1:0]     event_sequence;
  } locd_in_t;

  typedef struct packed {
    logic [1:0] edge_status;
    logic       cycle_found;
    logic       cycle_finding_new;
    logic       capacity_finding_new;
    logic       findings_overflow;
    logic [6:0] edges_stored;
    logic [5:0] findings_stored;
  } locd_out_t;

endpackage

[design/lock_order_cycle_detector_core.sv]
// ----------------------------------------------------------------------------
// Each transaction scans the edge table for a duplicate and, if there is none,
// walks it in reachability passes (up to one pass per node) and may scan the
// findings table. Throughput: one transaction at a time; all scans share one
// compare unit and one read port per table.
// Reset (rst_n low, synchronous) empties both tables and clears the control.
// ----------------------------------------------------------------------------
// lock_order_cycle_detector_core
// Takes lock order edges, keeps a table of distinct edges, walks the graph to
// detect lock order cycles and records cycle and capacity findings.
// ----------------------------------------------------------------------------
module lock_order_cycle_detector_core
  import locd_pkg::*;
#(
  parameter int EDGE_DEPTH    = EDGE_DEPTH_DEF,
  parameter int FINDING_DEPTH = FINDING_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  locd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output locd_out_t out_data
);

  localparam int EIDX_W = $clog2(EDGE_DEPTH);
  localparam int ECNT_W = $clog2(EDGE_DEPTH + 1);
  localparam int FIDX_W = (FINDING_DEPTH > 1) ? $clog2(FINDING_DEPTH) : 1;
  localparam int FCNT_W = $clog2(FINDING_DEPTH + 1);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DUP_RD  = 4'd1;
  localparam logic [3:0] ST_DUP_CMP = 4'd2;
  localparam logic [3:0] ST_WLK_RD  = 4'd3;
  localparam logic [3:0] ST_WLK_CMP = 4'd4;
  localparam logic [3:0] ST_FND_RD  = 4'd5;
  localparam logic [3:0] ST_FND_CMP = 4'd6;
  localparam logic [3:0] ST_WR_CYC  = 4'd7;
  localparam logic [3:0] ST_WR_CAP  = 4'd8;
  localparam logic [3:0] ST_FINISH  = 4'd9;
  localparam logic [3:0] ST_OUT     = 4'd10;

  // Edge table and findings table. They are never cleared: only entries
  // below the matching count are ever read.
  logic [LOCK_ID_BITS-1:0] e_src_mem [EDGE_DEPTH];
  logic [LOCK_ID_BITS-1:0] e_dst_mem [EDGE_DEPTH];
  logic [SEQ_BITS-1:0]     e_seq_mem [EDGE_DEPTH];
  logic                    f_kind_mem [FINDING_DEPTH];
  logic [LOCK_ID_BITS-1:0] f_first_mem [FINDING_DEPTH];
  logic [LOCK_ID_BITS-1:0] f_second_mem [FINDING_DEPTH];
  logic [SEQ_BITS-1:0]     f_seq_mem [FINDING_DEPTH];

  logic [LOCK_ID_BITS-1:0] e_src_rd_r, e_dst_rd_r;
  logic                    f_kind_rd_r;
  logic [LOCK_ID_BITS-1:0] f_first_rd_r, f_second_rd_r;

  logic [3:0]              state_r;
  locd_in_t                item_r;
  logic [EIDX_W-1:0]       eidx_r;
  logic [FIDX_W-1:0]       fidx_r;
  logic [ECNT_W-1:0]       ecnt_r;
  logic [FCNT_W-1:0]       fcnt_r;
  logic [NODE_COUNT-1:0]   reached_r;
  logic                    changed_r;
  logic                    hit_r;
  logic                    cyc_dup_r, cap_dup_r;
  logic                    cyc_new_r, cap_new_r, ovf_r;
  locd_out_t               out_data_r;
  logic                    out_valid_r;

  logic                    e_we, f_we;
  logic [LOCK_ID_BITS-1:0] f_first_wd, f_second_wd;
  logic                    f_kind_wd;
  logic [FIDX_W-1:0]       f_waddr;
  logic                    edge_last, find_last;
  logic                    table_full;

  assign edge_last  = (ECNT_W'(eidx_r) + ECNT_W'(1)) == ecnt_r;
  assign find_last  = (FCNT_W'(fidx_r) + FCNT_W'(1)) == fcnt_r;
  assign table_full = ecnt_r >= ECNT_W'(EDGE_DEPTH);

  // Table reads: the sequencer holds the address for the read cycle, the
  // data is registered and compared in the next cycle.
  always_ff @(posedge clk) begin
    e_src_rd_r    <= e_src_mem[eidx_r];
    e_dst_rd_r    <= e_dst_mem[eidx_r];
    f_kind_rd_r   <= f_kind_mem[fidx_r];
    f_first_rd_r  <= f_first_mem[fidx_r];
    f_second_rd_r <= f_second_mem[fidx_r];
  end

  assign e_we        = (state_r == ST_FINISH) && !table_full;
  assign f_kind_wd   = (state_r == ST_WR_CAP) ? KIND_CAPACITY : KIND_CYCLE;
  assign f_first_wd  = item_r.from_lock;
  assign f_second_wd = item_r.to_lock;
  assign f_waddr     = fcnt_r[FIDX_W-1:0];
  assign f_we = ((state_r == ST_WR_CYC && hit_r && !cyc_dup_r) ||
                 (state_r == ST_WR_CAP && table_full && !cap_dup_r)) &&
                (fcnt_r < FCNT_W'(FINDING_DEPTH));

  always_ff @(posedge clk) begin
    if (e_we) begin
      e_src_mem[ecnt_r[EIDX_W-1:0]] <= item_r.from_lock;
      e_dst_mem[ecnt_r[EIDX_W-1:0]] <= item_r.to_lock;
      e_seq_mem[ecnt_r[EIDX_W-1:0]] <= item_r.event_sequence;
    end
    if (f_we) begin
      f_kind_mem[f_waddr]   <= f_kind_wd;
      f_first_mem[f_waddr]  <= f_first_wd;
      f_second_mem[f_waddr] <= f_second_wd;
      f_seq_mem[f_waddr]    <= item_r.event_sequence;
    end
  end

  // Main sequencer. The walk keeps a set of reached lock ids, starting at
  // to_lock, and sweeps the edge table until a sweep adds nothing or
  // from_lock turns up in the set.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ecnt_r      <= '0;
      fcnt_r      <= '0;
      out_valid_r <= 1'b0;
      eidx_r      <= '0;
      fidx_r      <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            item_r    <= in_data;
            eidx_r    <= '0;
            fidx_r    <= '0;
            cyc_dup_r <= 1'b0;
            cap_dup_r <= 1'b0;
            cyc_new_r <= 1'b0;
            cap_new_r <= 1'b0;
            ovf_r     <= 1'b0;
            // An empty table only leaves the self edge case to decide.
            hit_r     <= (ecnt_r == '0) && (in_data.from_lock == in_data.to_lock);
            state_r   <= (ecnt_r == '0) ? ST_FND_RD : ST_DUP_RD;
          end
        end
        ST_DUP_RD: state_r <= ST_DUP_CMP;
        ST_DUP_CMP: begin
          if (e_src_rd_r == item_r.from_lock && e_dst_rd_r == item_r.to_lock) begin
            out_data_r.edge_status          <= STATUS_DUPLICATE;
            out_data_r.cycle_found          <= 1'b0;
            out_data_r.cycle_finding_new    <= 1'b0;
            out_data_r.capacity_finding_new <= 1'b0;
            out_data_r.findings_overflow    <= 1'b0;
            out_data_r.edges_stored         <= 7'(ecnt_r);
            out_data_r.findings_stored      <= 6'(fcnt_r);
            out_valid_r                     <= 1'b1;
            state_r                         <= ST_OUT;
          end else if (edge_last) begin
            eidx_r    <= '0;
            changed_r <= 1'b0;
            reached_r <= NODE_COUNT'(1) << item_r.to_lock;
            if (item_r.from_lock == item_r.to_lock) begin
              hit_r   <= 1'b1;
              state_r <= ST_FND_RD;
            end else begin
              state_r <= ST_WLK_RD;
            end
          end else begin
            eidx_r  <= eidx_r + EIDX_W'(1);
            state_r <= ST_DUP_RD;
          end
        end
        ST_WLK_RD: state_r <= ST_WLK_CMP;
        ST_WLK_CMP: begin
          if (reached_r[e_src_rd_r] && !reached_r[e_dst_rd_r] &&
              e_dst_rd_r == item_r.from_lock) begin
            hit_r   <= 1'b1;
            state_r <= ST_FND_RD;
          end else begin
            if (reached_r[e_src_rd_r] && !reached_r[e_dst_rd_r]) begin
              reached_r[e_dst_rd_r] <= 1'b1;
            end
            if (edge_last) begin
              eidx_r <= '0;
              if (changed_r || (reached_r[e_src_rd_r] && !reached_r[e_dst_rd_r])) begin
                changed_r <= 1'b0;
                state_r   <= ST_WLK_RD;
              end else begin
                state_r <= ST_FND_RD;
              end
            end else begin
              if (reached_r[e_src_rd_r] && !reached_r[e_dst_rd_r]) begin
                changed_r <= 1'b1;
              end
              eidx_r  <= eidx_r + EIDX_W'(1);
              state_r <= ST_WLK_RD;
            end
          end
        end
        ST_FND_RD: begin
          // Skip the findings scan when there is nothing to record or
          // nothing stored yet.
          if (fcnt_r == '0 || !(hit_r || table_full)) begin
            state_r <= ST_WR_CYC;
          end else begin
            state_r <= ST_FND_CMP;
          end
        end
        ST_FND_CMP: begin
          if (f_first_rd_r == item_r.from_lock && f_second_rd_r == item_r.to_lock) begin
            if (f_kind_rd_r == KIND_CYCLE) begin
              cyc_dup_r <= 1'b1;
            end else begin
              cap_dup_r <= 1'b1;
            end
          end
          if (find_last) begin
            state_r <= ST_WR_CYC;
          end else begin
            fidx_r  <= fidx_r + FIDX_W'(1);
            state_r <= ST_FND_RD;
          end
        end
        ST_WR_CYC: begin
          if (hit_r && !cyc_dup_r) begin
            if (f_we) begin
              fcnt_r    <= fcnt_r + FCNT_W'(1);
              cyc_new_r <= 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
          end
          state_r <= ST_WR_CAP;
        end
        ST_WR_CAP: begin
          if (table_full && !cap_dup_r) begin
            if (f_we) begin
              fcnt_r    <= fcnt_r + FCNT_W'(1);
              cap_new_r <= 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
          end
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          out_data_r.edge_status          <= table_full ? STATUS_DROPPED : STATUS_STORED;
          out_data_r.cycle_found          <= hit_r;
          out_data_r.cycle_finding_new    <= cyc_new_r;
          out_data_r.capacity_finding_new <= cap_new_r;
          out_data_r.findings_overflow    <= ovf_r;
          out_data_r.edges_stored         <= table_full ? 7'(ecnt_r) :
                                             7'(ecnt_r + ECNT_W'(1));
          out_data_r.findings_stored      <= 6'(fcnt_r);
          if (!table_full) begin
            ecnt_r <= ecnt_r + ECNT_W'(1);
          end
          out_valid_r <= 1'b1;
          state_r     <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The block never holds a result while it is open for a new transaction.
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("result pending while input open");

  // Table counts stay within their depths.
  a_edge_count: assert property (@(posedge clk) disable iff (!rst_n)
    ecnt_r <= ECNT_W'(EDGE_DEPTH)) else $error("edge count overflow");
  a_find_count: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= FCNT_W'(FINDING_DEPTH)) else $error("finding count overflow");

  // Every accepted transaction leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("accept did not start work");

endmodule

[tb/lock_order_cycle_detector_core_tb.sv]
// ----------------------------------------------------------------------------
// Lock order cycle detector testbench
// Offers lock order edges to the detector under random idling on both sides.
// A behavioral model of the edge graph and the findings table in this file
// predicts every result, and each result is checked field by field.
// ----------------------------------------------------------------------------
module lock_order_cycle_detector_core_tb;
  import locd_pkg::*;

  localparam int EDGES    = EDGE_DEPTH_DEF;
  localparam int FINDINGS = FINDING_DEPTH_DEF;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  locd_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  locd_out_t out_data;

  lock_order_cycle_detector_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the graph and the findings table.
  logic [LOCK_ID_BITS-1:0] graph_src[EDGES];
  logic [LOCK_ID_BITS-1:0] graph_dst[EDGES];
  int                      graph_count;
  logic                    finding_kind_q[FINDINGS];
  logic [LOCK_ID_BITS-1:0] finding_a[FINDINGS];
  logic [LOCK_ID_BITS-1:0] finding_b[FINDINGS];
  int                      logged_findings;

  locd_out_t expected_results[$];
  int        mismatches;
  int        results_seen;
  int        cycles_seen;
  int        drops_seen;
  int        overflows_seen;
  bit        quiet;        // no idling in the last part of the run
  bit        hold_output;  // long receiver hold-off requested

  // Closure over lock nodes: does 'start' reach 'goal' through stored edges?
  function automatic bit lock_reaches(logic [LOCK_ID_BITS-1:0] start,
                                      logic [LOCK_ID_BITS-1:0] goal);
    bit seen[NODE_COUNT];
    bit grew;
    if (start == goal) return 1'b1;
    foreach (seen[k]) seen[k] = 1'b0;
    seen[start] = 1'b1;
    do begin
      grew = 1'b0;
      for (int k = 0; k < graph_count; k++) begin
        if (seen[graph_src[k]] && !seen[graph_dst[k]]) begin
          seen[graph_dst[k]] = 1'b1;
          grew = 1'b1;
        end
      end
    end while (grew);
    return seen[goal];
  endfunction

  // Returns 1 when recorded, 0 when already present, 2 when lost.
  function automatic int record_finding(logic kind, logic [LOCK_ID_BITS-1:0] a,
                                        logic [LOCK_ID_BITS-1:0] b);
    for (int k = 0; k < logged_findings; k++)
      if (finding_kind_q[k] == kind && finding_a[k] == a && finding_b[k] == b)
        return 0;
    if (logged_findings >= FINDINGS) return 2;
    finding_kind_q[logged_findings] = kind;
    finding_a[logged_findings] = a;
    finding_b[logged_findings] = b;
    logged_findings++;
    return 1;
  endfunction

  function automatic locd_out_t predict_edge(locd_in_t edge_in);
    locd_out_t res;
    bit        dup;
    int        rc;
    res = '0;
    res.edge_status = STATUS_STORED;
    dup = 1'b0;
    for (int k = 0; k < graph_count; k++)
      if (graph_src[k] == edge_in.from_lock && graph_dst[k] == edge_in.to_lock) dup = 1'b1;
    if (dup) begin
      res.edge_status = STATUS_DUPLICATE;
    end else begin
      if (lock_reaches(edge_in.to_lock, edge_in.from_lock)) begin
        res.cycle_found = 1'b1;
        rc = record_finding(KIND_CYCLE, edge_in.from_lock, edge_in.to_lock);
        if (rc == 1) res.cycle_finding_new = 1'b1;
        if (rc == 2) res.findings_overflow = 1'b1;
      end
      if (graph_count >= EDGES) begin
        res.edge_status = STATUS_DROPPED;
        rc = record_finding(KIND_CAPACITY, edge_in.from_lock, edge_in.to_lock);
        if (rc == 1) res.capacity_finding_new = 1'b1;
        if (rc == 2) res.findings_overflow = 1'b1;
      end else begin
        graph_src[graph_count] = edge_in.from_lock;
        graph_dst[graph_count] = edge_in.to_lock;
        graph_count++;
      end
    end
    res.edges_stored = 7'(graph_count);
    res.findings_stored = 6'(logged_findings);
    return res;
  endfunction

  // Offers one edge, with an optional random gap first, and waits for its
  // acceptance. The prediction is made at the accepting edge. Valid stays up
  // after acceptance so the next edge can follow in the same step; a gap or
  // the end of the run drops it.
  task automatic send_edge(logic [LOCK_ID_BITS-1:0] a, logic [LOCK_ID_BITS-1:0] b,
                           logic [SEQ_BITS-1:0] seq);
    locd_in_t txn;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    txn.from_lock = a;
    txn.to_lock = b;
    txn.event_sequence = seq;
    in_valid <= 1'b1;
    in_data  <= txn;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_edge(txn));
  endtask

  task automatic send_random_edge(int span);
    send_edge(LOCK_ID_BITS'($urandom_range(0, span)), LOCK_ID_BITS'($urandom_range(0, span)),
              $urandom());
  endtask

  // Receiver stall: random bursts, a long hold-off on request, none when quiet.
  always @(posedge clk) begin
    if (!rst_n || quiet) out_stall <= 1'b0;
    else if (hold_output) out_stall <= 1'b1;
    else if (out_stall) out_stall <= ($urandom_range(0, 3) != 0);
    else out_stall <= ($urandom_range(0, 7) == 0);
  end

  // Checks each accepted result transaction against the oldest prediction.
  always @(posedge clk) begin
    locd_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result transaction, actual %p", $realtime, out_data);
      end else begin
        want = expected_results.pop_front();
        if (want.cycle_found) cycles_seen++;
        if (want.edge_status == STATUS_DROPPED) drops_seen++;
        if (want.findings_overflow) overflows_seen++;
        if (out_data.edge_status !== want.edge_status) begin
          mismatches++;
          $display("%0t: edge_status expected %0d actual %0d", $realtime,
                   want.edge_status, out_data.edge_status);
        end
        if (out_data.cycle_found !== want.cycle_found) begin
          mismatches++;
          $display("%0t: cycle_found expected %0d actual %0d", $realtime,
                   want.cycle_found, out_data.cycle_found);
        end
        if (out_data.cycle_finding_new !== want.cycle_finding_new) begin
          mismatches++;
          $display("%0t: cycle_finding_new expected %0d actual %0d", $realtime,
                   want.cycle_finding_new, out_data.cycle_finding_new);
        end
        if (out_data.capacity_finding_new !== want.capacity_finding_new) begin
          mismatches++;
          $display("%0t: capacity_finding_new expected %0d actual %0d", $realtime,
                   want.capacity_finding_new, out_data.capacity_finding_new);
        end
        if (out_data.findings_overflow !== want.findings_overflow) begin
          mismatches++;
          $display("%0t: findings_overflow expected %0d actual %0d", $realtime,
                   want.findings_overflow, out_data.findings_overflow);
        end
        if (out_data.edges_stored !== want.edges_stored) begin
          mismatches++;
          $display("%0t: edges_stored expected %0d actual %0d", $realtime,
                   want.edges_stored, out_data.edges_stored);
        end
        if (out_data.findings_stored !== want.findings_stored) begin
          mismatches++;
          $display("%0t: findings_stored expected %0d actual %0d", $realtime,
                   want.findings_stored, out_data.findings_stored);
        end
      end
    end
  end

  // Directed: extreme ids, self edges, duplicates, a short cycle and a long
  // chain that closes on itself.
  task automatic test_directed_edges();
    send_edge('0, '0, '0);                 // self edge is a cycle
    send_edge('0, '0, '1);                 // duplicate edge, nothing changes
    send_edge('1, '1, 32'h8000_0001);      // self edge on the top id
    send_edge('1, '1, 32'h8000_0001);      // duplicate of it
    send_edge('0, '1, 32'h5555_5555);
    send_edge('1, '0, 32'hAAAA_AAAA);      // two-lock cycle
    send_edge(6'd21, 6'd42, 32'h0F0F_0F0F);
    send_edge(6'd42, 6'd21, 32'hF0F0_F0F0);
    for (int k = 1; k < 6; k++) send_edge(6'(k), 6'(k + 1), 32'(k));
    send_edge(6'd6, 6'd1, 32'd77);         // closes a long chain
    send_edge(6'd3, 6'd2, 32'd78);         // cycle inside the chain
    send_edge(6'd5, 6'd4, 32'd79);
  endtask

  // Random edges over a few locks, so that duplicates and cycles are common.
  task automatic test_dense_graph(int count);
    repeat (count) send_random_edge(11);
  endtask

  // The receiver holds off while edges keep coming, so the detector backs up.
  task automatic test_output_backpressure();
    fork
      begin
        hold_output = 1'b1;
        repeat (400) @(posedge clk);
        hold_output = 1'b0;
      end
      repeat (6) send_random_edge(11);
    join
  endtask

  // Fill the edge table and keep going: capacity findings, findings overflow,
  // cycles on a full table and duplicate capacity findings.
  task automatic test_full_tables(int count);
    while (graph_count < EDGES) send_random_edge(63);
    repeat (count) begin
      if ($urandom_range(0, 2) == 0)
        send_edge(graph_src[$urandom_range(0, EDGES - 1)],
                  graph_dst[$urandom_range(0, EDGES - 1)], $urandom());
      else
        send_random_edge($urandom_range(0, 1) ? 7 : 63);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    graph_count = 0;
    logged_findings = 0;
    mismatches = 0;
    results_seen = 0;
    cycles_seen = 0;
    drops_seen = 0;
    overflows_seen = 0;
    quiet = 1'b0;
    hold_output = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_dense_graph(40);
    test_output_backpressure();
    test_full_tables(500);
    quiet = 1'b1;
    test_full_tables(80);
    wait_drained();
    $display("Checked %0d results: %0d cycles, %0d dropped edges, %0d lost findings.",
             results_seen, cycles_seen, drops_seen, overflows_seen);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Watchdog. The slowest edge is one whose walk needs one pass per lock on a
  // full graph.
  initial begin
    #400_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
